@@ sv/ser_pkg.sv @@
// shared constants, codes and helpers for the scanline edge rasterizer
`timescale 1ns / 1ps
package ser_pkg;

  localparam int MAX_ROWS  = 1024;
  localparam int FRAC_BITS = 4;

  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int CNT_W    = $clog2(MAX_ROWS + 1);
  localparam int HEIGHT_W = 11;
  localparam int COORD_W  = 16;
  localparam int COL_W    = 12;
  localparam int COLOR_W  = 32;
  localparam int YW       = COORD_W - FRAC_BITS + 2;
  localparam int DEN_W    = COORD_W + FRAC_BITS;
  localparam int NUM_W    = 40;
  localparam int MUL_W    = COORD_W + 2;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 32;
  localparam int ONE       = 1 << FRAC_BITS;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HEIGHT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_COLOR    = 1'b1;

  localparam logic MODE_EDGE = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic signed [NUM_W-1:0] COL_MIN = -NUM_W'(2048);
  localparam logic signed [NUM_W-1:0] COL_MAX = NUM_W'(2047);

  // ceil of a fixed point coordinate, in whole rows
  function automatic logic signed [YW-1:0] ceil_row(input logic signed [COORD_W-1:0] v);
    logic signed [COORD_W:0] s;
    s = (COORD_W+1)'(v) + (COORD_W+1)'(ONE - 1);
    return YW'(s >>> FRAC_BITS);
  endfunction

endpackage

@@ sv/ser_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
module ser_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/ser_div.sv @@
// iterative floor divider, one quotient bit per cycle
`timescale 1ns / 1ps
module ser_div (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic signed [ser_pkg::NUM_W-1:0]       num,
  input  logic        [ser_pkg::DEN_W-1:0]       den,
  output logic                                   done,
  output logic signed [ser_pkg::NUM_W-1:0]       quo,
  output logic        [ser_pkg::DEN_W-1:0]       rem
);
  import ser_pkg::*;

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [NUM_W-1:0] qr;
  logic [DEN_W-1:0] rr;
  logic [DEN_W-1:0] dr;
  logic             neg;
  logic [DEN_W:0]   trial;
  logic             fit;

  assign trial = {rr, qr[NUM_W-1]};
  assign fit   = trial >= {1'b0, dr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= num[NUM_W-1];
        qr   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        rr   <= '0;
        dr   <= den;
      end else if (busy) begin
        if (cnt == CW'(NUM_W)) begin
          // sign fix toward floor
          busy <= 1'b0;
          done <= 1'b1;
          if (!neg) begin
            quo <= signed'(qr);
            rem <= rr;
          end else if (rr != '0) begin
            quo <= signed'(~qr);
            rem <= dr - rr;
          end else begin
            quo <= signed'(NUM_W'(-qr));
            rem <= '0;
          end
        end else begin
          cnt <= cnt + CW'(1);
          rr  <= fit ? DEN_W'(trial - {1'b0, dr}) : DEN_W'(trial);
          qr  <= {qr[NUM_W-2:0], fit};
        end
      end
    end
  end

endmodule

@@ sv/scanline_edge_rasterizer.sv @@
// top level: edge scan conversion into a per-row span store, span readback
//
//  channel | signals                                            | dir | flow
//  --------+----------------------------------------------------+-----+-------------
//  input   | in_valid in_stall mode top_x top_y bottom_x ...    | in  | valid/stall
//  output  | out_valid out_stall rows_written span_row ...      | out | valid/stall
//  config  | cfg_valid cfg_ready cfg_index cfg_data             | in  | valid/ready
//
// an edge beat runs its setup (two multiplies on one shared multiplier, then
// two passes of the bit-serial divider), then stores one row per cycle and
// ends in the done state; a read beat does a registered ram read first, while
// a read past the active height and an edge with no rows go straight to done
// after reset the span store is cleared one row a cycle, all MAX_ROWS rows, with
// in_stall high; config writes are taken at any time (cfg_ready is always high)
// a finished result sits in the output register; out_stall holds it and the
// block then waits in its done state before taking the next input beat
`timescale 1ns / 1ps
module scanline_edge_rasterizer (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   mode,
  input  logic signed [ser_pkg::COORD_W-1:0]     top_x,
  input  logic signed [ser_pkg::COORD_W-1:0]     top_y,
  input  logic signed [ser_pkg::COORD_W-1:0]     bottom_x,
  input  logic signed [ser_pkg::COORD_W-1:0]     bottom_y,
  input  logic                                   side,
  input  logic        [ser_pkg::ROW_W-1:0]       row,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic        [ser_pkg::CNT_W-1:0]       rows_written,
  output logic        [ser_pkg::ROW_W-1:0]       span_row,
  output logic signed [ser_pkg::COL_W-1:0]       span_left,
  output logic signed [ser_pkg::COL_W-1:0]       span_right,
  output logic        [ser_pkg::COLOR_W-1:0]     span_color,
  output logic                                   row_invalid,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic        [ser_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic        [ser_pkg::CFG_W-1:0]       cfg_data
);
  import ser_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_MUL_A  = 4'd2;
  localparam logic [3:0] S_MUL_B  = 4'd3;
  localparam logic [3:0] S_SUM    = 4'd4;
  localparam logic [3:0] S_NGO    = 4'd5;
  localparam logic [3:0] S_NWAIT  = 4'd6;
  localparam logic [3:0] S_SGO    = 4'd7;
  localparam logic [3:0] S_SWAIT  = 4'd8;
  localparam logic [3:0] S_ROWS   = 4'd9;
  localparam logic [3:0] S_READ   = 4'd10;
  localparam logic [3:0] S_READ_W = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  logic [3:0] state;

  // config registers
  logic [HEIGHT_W-1:0] active_height;
  logic [COLOR_W-1:0]  fill_color;
  logic [CNT_W-1:0]    h_eff;
  logic signed [YW-1:0] h_s;

  // item registers
  logic                       side_r;
  logic [ROW_W-1:0]           row_r;
  logic signed [COORD_W-1:0]  tx_r;
  logic signed [COORD_W-1:0]  ty_r;
  logic signed [COORD_W:0]    dx_r;
  logic signed [COORD_W:0]    dy_r;
  logic signed [YW-1:0]       y0_r;
  logic signed [YW-1:0]       y1_r;
  logic signed [YW-1:0]       y_r;
  logic [ROW_W-1:0]           clr_cnt;

  // setup arithmetic
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [NUM_W-1:0]  acc_r;

  // dda state: x = q + r/D, step = qs + rs/D
  logic signed [NUM_W-1:0] q_r;
  logic [DEN_W-1:0]        r_r;
  logic signed [NUM_W-1:0] qs_r;
  logic [DEN_W-1:0]        rs_r;
  logic [DEN_W-1:0]        den;
  logic [DEN_W:0]          r_sum;
  logic signed [NUM_W-1:0] c_full;
  logic [COL_W-1:0]        c_sat;

  // divider
  logic                    div_start;
  logic signed [NUM_W-1:0] div_num;
  logic                    div_done;
  logic signed [NUM_W-1:0] div_quo;
  logic [DEN_W-1:0]        div_rem;

  // staged result
  logic [CNT_W-1:0]   res_rows;
  logic [ROW_W-1:0]   res_row;
  logic [COL_W-1:0]   res_left;
  logic [COL_W-1:0]   res_right;
  logic [COLOR_W-1:0] res_color;
  logic               res_inv;

  // ram ports
  logic             we_l;
  logic             we_r;
  logic [ROW_W-1:0] waddr;
  logic [COL_W-1:0] wdata;
  logic             re;
  logic [COL_W-1:0] rdata_l;
  logic [COL_W-1:0] rdata_r;

  // edge setup at accept
  logic signed [COORD_W:0] dy_c;
  logic signed [YW-1:0]    yt_c;
  logic signed [YW-1:0]    yb_c;
  logic signed [YW-1:0]    y0_c;
  logic signed [YW-1:0]    y1_c;

  logic in_acc;
  logic out_load;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_load  = (state == S_DONE) && (!out_valid || !out_stall);

  assign h_eff = (32'(active_height) < 32'(MAX_ROWS)) ? CNT_W'(active_height)
                                                      : CNT_W'(MAX_ROWS);
  assign h_s   = signed'(YW'(h_eff));

  assign dy_c = (COORD_W+1)'(bottom_y) - (COORD_W+1)'(top_y);
  assign yt_c = ceil_row(top_y);
  assign yb_c = ceil_row(bottom_y);
  assign y0_c = (yt_c < 0) ? '0 : yt_c;
  assign y1_c = (yb_c > h_s) ? h_s : yb_c;

  // one shared multiplier for both setup products
  always_comb begin
    if (state == S_MUL_A) begin
      mul_a = MUL_W'(tx_r);
      mul_b = MUL_W'(dy_r);
    end else begin
      mul_a = (MUL_W'(y0_r) <<< FRAC_BITS) - MUL_W'(ty_r);
      mul_b = MUL_W'(dx_r);
    end
  end
  assign mul_p = mul_a * mul_b;

  assign den       = DEN_W'(dy_r) << FRAC_BITS;
  assign div_start = (state == S_NGO) || (state == S_SGO);
  assign div_num   = (state == S_NGO) ? acc_r : (NUM_W'(dx_r) <<< FRAC_BITS);

  ser_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // column for the current row: ceil then saturate
  assign c_full = q_r + NUM_W'(r_r != '0);
  always_comb begin
    if (c_full < COL_MIN) begin
      c_sat = COL_W'(COL_MIN);
    end else if (c_full > COL_MAX) begin
      c_sat = COL_W'(COL_MAX);
    end else begin
      c_sat = COL_W'(c_full);
    end
  end
  assign r_sum = {1'b0, r_r} + {1'b0, rs_r};

  // span store write and read
  always_comb begin
    we_l  = 1'b0;
    we_r  = 1'b0;
    waddr = y_r[ROW_W-1:0];
    wdata = c_sat;
    if (state == S_CLEAR) begin
      we_l  = 1'b1;
      we_r  = 1'b1;
      waddr = clr_cnt;
      wdata = '0;
    end else if (state == S_ROWS) begin
      we_l = !side_r;
      we_r = side_r;
    end
  end
  assign re = (state == S_READ);

  ser_ram #(.WIDTH(COL_W), .DEPTH(MAX_ROWS)) u_ram_left (
    .clk   (clk),
    .we    (we_l),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (row_r),
    .rdata (rdata_l)
  );

  ser_ram #(.WIDTH(COL_W), .DEPTH(MAX_ROWS)) u_ram_right (
    .clk   (clk),
    .we    (we_r),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (row_r),
    .rdata (rdata_r)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      active_height <= HEIGHT_W'(1024);
      fill_color    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ACTIVE_HEIGHT: active_height <= cfg_data[HEIGHT_W-1:0];
        CFG_FILL_COLOR:    fill_color    <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + ROW_W'(1);
          if (clr_cnt == ROW_W'(MAX_ROWS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            side_r    <= side;
            row_r     <= row;
            tx_r      <= top_x;
            ty_r      <= top_y;
            dx_r      <= (COORD_W+1)'(bottom_x) - (COORD_W+1)'(top_x);
            dy_r      <= dy_c;
            y0_r      <= y0_c;
            y1_r      <= y1_c;
            y_r       <= y0_c;
            res_rows  <= '0;
            res_row   <= '0;
            res_left  <= '0;
            res_right <= '0;
            res_color <= '0;
            res_inv   <= 1'b0;
            if (mode == MODE_READ) begin
              res_row   <= row;
              res_color <= fill_color;
              if (CNT_W'(row) >= h_eff) begin
                res_inv <= 1'b1;
                state   <= S_DONE;
              end else begin
                state <= S_READ;
              end
            end else if (dy_c > 0 && y0_c < y1_c) begin
              state <= S_MUL_A;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_MUL_A: begin
          acc_r <= NUM_W'(mul_p);
          state <= S_MUL_B;
        end
        S_MUL_B: begin
          prod_r <= mul_p;
          state  <= S_SUM;
        end
        S_SUM: begin
          acc_r <= acc_r + NUM_W'(prod_r);
          state <= S_NGO;
        end
        S_NGO: begin
          state <= S_NWAIT;
        end
        S_NWAIT: begin
          if (div_done) begin
            q_r   <= div_quo;
            r_r   <= div_rem;
            state <= S_SGO;
          end
        end
        S_SGO: begin
          state <= S_SWAIT;
        end
        S_SWAIT: begin
          if (div_done) begin
            qs_r  <= div_quo;
            rs_r  <= div_rem;
            state <= S_ROWS;
          end
        end
        S_ROWS: begin
          // one row stored per cycle, exact remainder carry
          res_rows <= res_rows + CNT_W'(1);
          y_r      <= y_r + YW'(1);
          if (r_sum >= {1'b0, den}) begin
            r_r <= DEN_W'(r_sum - {1'b0, den});
            q_r <= q_r + qs_r + NUM_W'(1);
          end else begin
            r_r <= DEN_W'(r_sum);
            q_r <= q_r + qs_r;
          end
          if (y_r == y1_r - YW'(1)) begin
            state <= S_DONE;
          end
        end
        S_READ: begin
          state <= S_READ_W;
        end
        S_READ_W: begin
          res_left  <= rdata_l;
          res_right <= rdata_r;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rows_written <= res_rows;
      span_row     <= res_row;
      span_left    <= signed'(res_left);
      span_right   <= signed'(res_right);
      span_color   <= res_color;
      row_invalid  <= res_inv;
    end
  end

  // an invalid read carries empty slots
  a_inv_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && row_invalid |-> span_left == '0 && span_right == '0)
    else $error("invalid row read returned slot data");

  // an edge beat that stored rows carries no colour and is not flagged invalid
  a_edge_nocolor: assert property (@(posedge clk) disable iff (rst)
    out_valid && rows_written != '0 |-> span_color == '0 && !row_invalid)
    else $error("edge result carries span fields");

  // rows are stored only inside the active height
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    state == S_ROWS |-> y_r >= 0 && y_r < h_s)
    else $error("row write outside active height");

  // the divider only finishes while the sequencer waits for it
  a_div_launch: assert property (@(posedge clk) disable iff (rst)
    div_done |-> $past(state) == S_NWAIT || $past(state) == S_SWAIT)
    else $error("divider finished outside a wait state");

endmodule

@@ bench/scanline_edge_rasterizer_test.sv @@
// self-checking bench for the scanline edge rasterizer: random triangles, span reads, config phases
`timescale 1ns / 1ps
module scanline_edge_rasterizer_test;
  import ser_pkg::*;

  typedef struct {
    logic                      mode;
    logic signed [COORD_W-1:0] tx, ty, bx, by;
    logic                      side;
    logic [ROW_W-1:0]          row;
  } raster_beat_t;

  typedef struct {
    logic [CNT_W-1:0]          rows;
    logic [ROW_W-1:0]          srow;
    logic signed [COL_W-1:0]   left, right;
    logic [COLOR_W-1:0]        color;
    logic                      inval;
  } span_result_t;

  logic clk, rst;
  logic in_valid, in_stall, mode, side;
  logic signed [COORD_W-1:0] top_x, top_y, bottom_x, bottom_y;
  logic [ROW_W-1:0] row;
  logic out_valid, out_stall;
  logic [CNT_W-1:0] rows_written;
  logic [ROW_W-1:0] span_row;
  logic signed [COL_W-1:0] span_left, span_right;
  logic [COLOR_W-1:0] span_color;
  logic row_invalid;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  scanline_edge_rasterizer dut (.*);

  // predictor state: mirror of the span store and the two registers
  logic [COL_W-1:0]    mirror_store [0:2*MAX_ROWS-1];
  logic [HEIGHT_W-1:0] mirror_height;
  logic [COLOR_W-1:0]  mirror_color;

  raster_beat_t pending_beats[$];
  span_result_t expected_spans[$];
  int  errors = 0;
  bit  quiet = 0;
  int  beats_taken = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // exact ceil of n/d for positive d, c-style truncating divide underneath
  function automatic longint ceil_quot(longint n, longint d);
    longint q;
    q = n / d;
    if (n % d > 0) q++;
    return q;
  endfunction

  // updates the mirror and returns the result the block should produce
  function automatic span_result_t rasterize_beat(raster_beat_t b);
    span_result_t r;
    longint h, tx, ty, bx, by, dy, dx, y0, y1, y, c, cnt;
    r = '{default: '0};
    h = (mirror_height < MAX_ROWS) ? mirror_height : MAX_ROWS;
    if (b.mode == MODE_EDGE) begin
      tx = b.tx; ty = b.ty; bx = b.bx; by = b.by;
      dy = by - ty;
      dx = bx - tx;
      cnt = 0;
      if (dy > 0) begin
        y0 = ceil_quot(ty, ONE);
        y1 = ceil_quot(by, ONE);
        if (y0 < 0) y0 = 0;
        if (y1 > h) y1 = h;
        for (y = y0; y < y1; y++) begin
          c = ceil_quot(tx * dy + (y * ONE - ty) * dx, dy * ONE);
          if (c < -2048) c = -2048;
          if (c > 2047) c = 2047;
          mirror_store[y * 2 + b.side] = c[COL_W-1:0];
          cnt++;
        end
      end
      r.rows = cnt[CNT_W-1:0];
    end else begin
      r.srow  = b.row;
      r.color = mirror_color;
      if (b.row >= h) begin
        r.inval = 1'b1;
      end else begin
        r.left  = mirror_store[2 * b.row];
        r.right = mirror_store[2 * b.row + 1];
      end
    end
    return r;
  endfunction

  // driver: one beat at a time from the pending queue, random gaps
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      mode     <= 1'b0;
      top_x    <= '0;
      top_y    <= '0;
      bottom_x <= '0;
      bottom_y <= '0;
      side     <= 1'b0;
      row      <= '0;
    end else if (!in_valid || !in_stall) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(0, 17);
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        raster_beat_t b;
        b = pending_beats.pop_front();
        in_valid <= 1'b1;
        mode <= b.mode; top_x <= b.tx; top_y <= b.ty;
        bottom_x <= b.bx; bottom_y <= b.by; side <= b.side; row <= b.row;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall: random bursts plus one long hold-off once the run is under way
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (!hold_done && beats_taken >= 40) begin
      hold_done <= 1'b1;
      hold_left <= 600;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end else if (!quiet && $urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(1, 18);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: predict on accepted input beats, check accepted output beats
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst) begin
      mirror_height = 11'd1024;
      mirror_color  = '0;
      for (int i = 0; i < 2 * MAX_ROWS; i++) mirror_store[i] = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ACTIVE_HEIGHT) mirror_height = cfg_data[HEIGHT_W-1:0];
        else if (cfg_index == CFG_FILL_COLOR) mirror_color = cfg_data;
      end
      if (in_valid && !in_stall) begin
        raster_beat_t b;
        b = '{mode, top_x, top_y, bottom_x, bottom_y, side, row};
        expected_spans.push_back(rasterize_beat(b));
        beats_taken++;
      end
      if (out_valid && !out_stall) begin
        if (expected_spans.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          span_result_t e;
          e = expected_spans.pop_front();
          if (rows_written !== e.rows) begin
            $error("rows_written: expected %0d got %0d", e.rows, rows_written); errors++;
          end
          if (span_row !== e.srow) begin
            $error("span_row: expected %0d got %0d", e.srow, span_row); errors++;
          end
          if (span_left !== e.left) begin
            $error("span_left: expected %0d got %0d", e.left, span_left); errors++;
          end
          if (span_right !== e.right) begin
            $error("span_right: expected %0d got %0d", e.right, span_right); errors++;
          end
          if (span_color !== e.color) begin
            $error("span_color: expected %h got %h", e.color, span_color); errors++;
          end
          if (row_invalid !== e.inval) begin
            $error("row_invalid: expected %0d got %0d", e.inval, row_invalid); errors++;
          end
        end
      end
      // watchdog: its limit outlasts the longest edge, the receiver hold-off and the clearing
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else if (++idle_cycles >= 20000) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic raster_beat_t edge_beat(int tx, int ty, int bx, int by, bit s);
    raster_beat_t b;
    b = '{mode: MODE_EDGE, tx: tx[15:0], ty: ty[15:0], bx: bx[15:0], by: by[15:0],
          side: s, row: '0};
    return b;
  endfunction

  function automatic raster_beat_t read_beat(int r);
    raster_beat_t b;
    b = '{mode: MODE_READ, tx: $urandom, ty: $urandom, bx: $urandom, by: $urandom,
          side: $urandom, row: r[ROW_W-1:0]};
    return b;
  endfunction

  // whole-field noise: every field, mode included, drawn at random
  function automatic raster_beat_t noise_beat();
    raster_beat_t b;
    b = '{mode: $urandom, tx: $urandom, ty: $urandom, bx: $urandom, by: $urandom,
          side: $urandom, row: $urandom};
    return b;
  endfunction

  // clamp an int into the 16-bit coordinate range
  function automatic int clip16(int v);
    return (v < -32768) ? -32768 : (v > 32767) ? 32767 : v;
  endfunction

  // a triangle as edge beats for its long side and two short sides, random x and y
  // spread around the active rows, followed by two reads of rows from its top down to 40 rows below
  task automatic push_triangle(int hrows);
    int ys[3], xs[3], t, base, k;
    bit hs;
    base = $urandom_range(0, hrows * ONE) - 4 * ONE;
    for (k = 0; k < 3; k++) begin
      ys[k] = clip16(base + $urandom_range(0, 40 * ONE));
      xs[k] = ($urandom_range(0, 3) == 0) ? int'($signed(16'($urandom)))
                                           : $urandom_range(0, 300 * ONE) - 20 * ONE;
    end
    for (k = 0; k < 2; k++)
      for (t = 0; t < 2 - k; t++)
        if (ys[t] > ys[t+1]) begin
          {ys[t], ys[t+1]} = {ys[t+1], ys[t]};
          {xs[t], xs[t+1]} = {xs[t+1], xs[t]};
        end
    hs = $urandom;
    pending_beats.push_back(edge_beat(xs[0], ys[0], xs[2], ys[2], hs));
    pending_beats.push_back(edge_beat(xs[0], ys[0], xs[1], ys[1], !hs));
    pending_beats.push_back(edge_beat(xs[1], ys[1], xs[2], ys[2], !hs));
    for (k = 0; k < 2; k++)
      pending_beats.push_back(read_beat((ys[0] >>> FRAC_BITS) + $urandom_range(0, 40)));
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_beats.size() > 0 || in_valid || expected_spans.size() > 0);
    repeat (10) @(posedge clk);
  endtask

  logic [CFG_W-1:0] heights [5];
  initial begin
    int p, n, hr;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    rst = 1;
    repeat (2) @(posedge clk);
    rst <= 0;

    // extremes of height: full, one row, zero, above the store size, random
    heights = '{32'd1024, 32'd1, 32'd0, 32'd2047, 32'($urandom_range(16, 1024))};
    for (p = 0; p < 5; p++) begin
      cfg_write(CFG_ACTIVE_HEIGHT, heights[p]);
      cfg_write(CFG_FILL_COLOR, (p == 0) ? 32'hFFFF_FFFF : (p == 1) ? 32'h0 : $urandom);
      hr = (heights[p] == 0) ? 1 : (heights[p] > MAX_ROWS) ? MAX_ROWS : heights[p];
      if (p == 0) begin
        // directed: extremes, flat and inverted edges, saturation, both sides
        pending_beats.push_back(edge_beat(-32768, -32768, 32767, 32767, 0));
        pending_beats.push_back(edge_beat(32767, -32768, -32768, 32767, 1));
        pending_beats.push_back(read_beat(0));
        pending_beats.push_back(read_beat(1023));
        pending_beats.push_back(edge_beat(100, 80, 300, 80, 0));
        pending_beats.push_back(edge_beat(100, 90, 300, 80, 1));
        pending_beats.push_back(edge_beat(-32768, 0, -32768, 200, 0));
        pending_beats.push_back(edge_beat(32767, 0, 32767, 200, 1));
        pending_beats.push_back(read_beat(5));
        pending_beats.push_back(edge_beat(17, 3, 50, 17, 0));
        pending_beats.push_back(edge_beat(-5, -40, 64, 47, 1));
        pending_beats.push_back(read_beat(1));
        pending_beats.push_back(read_beat(2));
        pending_beats.push_back(edge_beat(0, 16350, 40, 32767, 1));
        pending_beats.push_back(read_beat(1022));
      end
      if (p == 4) quiet = 1;
      n = (p == 2) ? 40 : 115;
      while (n > 0) begin
        if ($urandom_range(0, 4) == 0) begin
          pending_beats.push_back(($urandom_range(0, 1)) ? noise_beat()
                                                         : read_beat($urandom_range(0, 1023)));
          n--;
        end else begin
          push_triangle(hr);
          n -= 5;
        end
      end
      wait_drained();
    end
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule

@@ scanline_edge_rasterizer.f @@
sv/ser_pkg.sv
sv/ser_ram.sv
sv/ser_div.sv
sv/scanline_edge_rasterizer.sv
bench/scanline_edge_rasterizer_test.sv
